/* rtl/csg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths, register indexes and helper functions for the cubed-sphere grid point block.
// It depends on nothing else. The top level, the CORDIC pipeline and the checker import it.
package csg_pkg;

    localparam int COL_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int FACE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int LON_W      = 25;
    localparam int LAT_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FACE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 3'd4;

    localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd2;

    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;
    localparam int REM_W      = SIZE_W + 1;

    localparam int PROD_W     = 42;
    localparam int PT_W       = 46;
    localparam int COORD_W    = 32;
    localparam int SH_W       = 4;
    localparam int FRAC_BITS  = 30;
    localparam int SHIFT_BASE = 30;

    localparam int IN_W         = 34;
    localparam int CX_W         = 36;
    localparam int ANG_W        = 34;
    localparam int CORDIC_STEPS = 31;

    localparam int HY_W = 63;
    localparam int R_W  = 33;
    localparam logic [HY_W-1:0] INV_GAIN  = 63'h26DD3B6A;
    localparam logic [HY_W-1:0] HY_ROUND  = 63'h2000_0000;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;

    localparam int M_W   = 33;
    localparam int PR_W  = 65;
    localparam int PC_W  = 57;
    localparam int QE_W  = 25;
    localparam int PP_W  = 58;
    localparam int DEG_SHIFT = 40;
    localparam logic [63:0] DEG_HALF_TURN = 64'd11796480;
    localparam logic [63:0] PI_DIV        = 64'd3373259426;
    localparam logic [63:0] PI_HALF_INT   = 64'd1686629713;
    localparam logic [63:0] DEG_RECIP     = (DEG_HALF_TURN << DEG_SHIFT) / PI_DIV;
    localparam logic [LON_W-1:0] LON_LIMIT = 25'd11796480;
    localparam logic [LON_W-1:0] LAT_LIMIT = 25'd5898240;

    localparam int LATENCY = DIV_STAGES + 5 + 2 * (CORDIC_STEPS + 1) + 1 + 4;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_steps(input div_state_t st,
                                             input logic [DIV_BITS-1:0] bits,
                                             input logic [SIZE_W-1:0] den);
        div_state_t r;
        logic [REM_W-1:0] t;
        r = st;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            t = {r.rem[REM_W-2:0], bits[b]};
            if (t >= {1'b0, den}) begin
                r.rem = t - {1'b0, den};
                r.quo = {r.quo[DIV_W-2:0], 1'b1};
            end else begin
                r.rem = t;
                r.quo = {r.quo[DIV_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [PT_W-1:0] scale_term(input logic signed [2:0] k,
                                                          input logic [PROD_W-1:0] v);
        logic signed [PT_W-1:0] e;
        e = $signed(PT_W'(v));
        case (k)
            3'b001:  return e;
            3'b010:  return e <<< 1;
            3'b111:  return -e;
            3'b110:  return -(e <<< 1);
            default: return '0;
        endcase
    endfunction

    // Arctangent of 2^-k in Q30 from its power series, evaluated at elaboration.
    function automatic logic [ANG_W-1:0] atan_q30(input int k);
        logic [63:0] sum;
        logic [63:0] term;
        int n;
        sum = '0;
        if (k == 0) begin
            sum = (PI_Q62 >> 2) + 64'h8000_0000;
        end else begin
            for (n = 0; k * (2 * n + 1) <= 62; n++) begin
                term = (64'd1 << (62 - k * (2 * n + 1))) / 64'(2 * n + 1);
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sum = sum + 64'h8000_0000;
        end
        return ANG_W'(sum >> 32);
    endfunction

endpackage

/* rtl/cubed_sphere_grid_point.sv */
`timescale 1ns / 1ps
// An accepted start passes through 8 divider stages for the grid steps, 5 stages for the point
// and its scaling, two 32-stage CORDIC pipelines, one hypot multiply stage and 4 stages of degree
// conversion before the done strobe. One item is taken every cycle while busy is low.
// busy is high only during reset and is cleared at the next clock edge; results cannot be held off.
// Reset clears all valid bits and returns the face and size registers to their reset values.
module cubed_sphere_grid_point
    import csg_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COL_W-1:0]             col_index,
    input  logic [COL_W-1:0]             row_index,
    output logic                         done,
    output logic signed [LON_W-1:0]      longitude,
    output logic signed [LAT_W-1:0]      latitude,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v < MIN_SIZE)
        begin
            return MIN_SIZE;
        end
        if (32'(v) > 32'(MAX_POINTS))
        begin
            return SIZE_W'(MAX_POINTS);
        end
        return v;
    endfunction

    function automatic logic signed [FACE_W-1:0] axis_comp(input logic [FACE_W-1:0] v);
        return (v == 2'b10) ? 2'sb11 : $signed(v);
    endfunction

    logic                      busy_reg;
    logic [FACE_W-1:0]         face_x_reg;
    logic [FACE_W-1:0]         face_y_reg;
    logic [FACE_W-1:0]         face_z_reg;
    logic [SIZE_W-1:0]         size_i_reg;
    logic [SIZE_W-1:0]         size_j_reg;
    logic                      accept;

    assign busy      = busy_reg;
    assign cfg_ready = ~busy_reg;
    assign accept    = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            face_x_reg <= 2'd1;
            face_y_reg <= 2'd0;
            face_z_reg <= 2'd0;
            size_i_reg <= MIN_SIZE;
            size_j_reg <= MIN_SIZE;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FACE_X: face_x_reg <= cfg_data[FACE_W-1:0];
                    REG_FACE_Y: face_y_reg <= cfg_data[FACE_W-1:0];
                    REG_FACE_Z: face_z_reg <= cfg_data[FACE_W-1:0];
                    REG_SIZE_I: size_i_reg <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_J: size_j_reg <= cfg_data[SIZE_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Face axes and step divisors follow registers which only the user holds while items run.
    logic signed [FACE_W-1:0]  f_x;
    logic signed [FACE_W-1:0]  f_y;
    logic signed [FACE_W-1:0]  f_z;
    logic signed [2:0]         u_c [3];
    logic signed [2:0]         w_c [3];
    logic signed [3:0]         c_c [3];
    logic [SIZE_W-1:0]         den_i;
    logic [SIZE_W-1:0]         den_j;
    logic [DIV_W-1:0]          num_i;
    logic [DIV_W-1:0]          num_j;

    always_comb
    begin
        f_x    = axis_comp(face_x_reg);
        f_y    = axis_comp(face_y_reg);
        f_z    = axis_comp(face_z_reg);
        u_c[0] = 3'(f_z);
        u_c[1] = 3'(f_x);
        u_c[2] = 3'(f_y);
        w_c[0] = 3'(f_y) * 3'(f_y) - 3'(f_z) * 3'(f_x);
        w_c[1] = 3'(f_z) * 3'(f_z) - 3'(f_x) * 3'(f_y);
        w_c[2] = 3'(f_x) * 3'(f_x) - 3'(f_y) * 3'(f_z);
        c_c[0] = 4'(f_x) - 4'(u_c[0]) - 4'(w_c[0]);
        c_c[1] = 4'(f_y) - 4'(u_c[1]) - 4'(w_c[1]);
        c_c[2] = 4'(f_z) - 4'(u_c[2]) - 4'(w_c[2]);
        den_i  = clamp_size(size_i_reg) - SIZE_W'(1);
        den_j  = clamp_size(size_j_reg) - SIZE_W'(1);
        num_i  = 32'h8000_0000 + DIV_W'(den_i >> 1);
        num_j  = 32'h8000_0000 + DIV_W'(den_j >> 1);
    end

    logic [DIV_STAGES-1:0]     dv_valid_reg;
    div_state_t                dv_i_reg   [DIV_STAGES];
    div_state_t                dv_j_reg   [DIV_STAGES];
    logic [COL_W-1:0]          dv_col_reg [DIV_STAGES];
    logic [COL_W-1:0]          dv_row_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        div_state_t       st_i;
        div_state_t       st_j;
        logic [COL_W-1:0] col_in;
        logic [COL_W-1:0] row_in;

        if (s == 0)
        begin : g_first
            assign st_i   = '0;
            assign st_j   = '0;
            assign col_in = col_index;
            assign row_in = row_index;
        end
        else
        begin : g_later
            assign st_i   = dv_i_reg[s-1];
            assign st_j   = dv_j_reg[s-1];
            assign col_in = dv_col_reg[s-1];
            assign row_in = dv_row_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            dv_i_reg[s]   <= div_steps(st_i, num_i[DIV_W-1-DIV_BITS*s -: DIV_BITS], den_i);
            dv_j_reg[s]   <= div_steps(st_j, num_j[DIV_W-1-DIV_BITS*s -: DIV_BITS], den_j);
            dv_col_reg[s] <= col_in;
            dv_row_reg[s] <= row_in;
        end
    end

    logic                      mu_valid_reg;
    logic [PROD_W-1:0]         mu_i_reg;
    logic [PROD_W-1:0]         mu_j_reg;
    logic                      pt_valid_reg;
    logic signed [PT_W-1:0]    pt_reg  [3];
    logic                      ab_valid_reg;
    logic [PT_W-2:0]           ab_reg  [3];
    logic                      ab_neg_reg [3];
    logic                      sh_valid_reg;
    logic [PT_W-2:0]           sh_ab_reg  [3];
    logic                      sh_neg_reg [3];
    logic [SH_W-1:0]           sh_reg;
    logic [SH_W-1:0]           sh_next;
    logic [PT_W-2:0]           ab_or;
    logic                      hv_valid_reg;
    logic signed [COORD_W-1:0] hv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
            mu_valid_reg <= 1'b0;
            pt_valid_reg <= 1'b0;
            ab_valid_reg <= 1'b0;
            sh_valid_reg <= 1'b0;
            hv_valid_reg <= 1'b0;
        end
        else
        begin
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-2:0], accept};
            mu_valid_reg <= dv_valid_reg[DIV_STAGES-1];
            pt_valid_reg <= mu_valid_reg;
            ab_valid_reg <= pt_valid_reg;
            sh_valid_reg <= ab_valid_reg;
            hv_valid_reg <= sh_valid_reg;
        end
    end

    always_comb
    begin
        ab_or   = ab_reg[0] | ab_reg[1] | ab_reg[2];
        sh_next = '0;
        for (int b = SHIFT_BASE + 1; b < PT_W - 1; b++)
        begin
            if (ab_or[b])
            begin
                sh_next = SH_W'(b - SHIFT_BASE);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mu_i_reg <= PROD_W'(dv_i_reg[DIV_STAGES-1].quo) * PROD_W'(dv_col_reg[DIV_STAGES-1]);
        mu_j_reg <= PROD_W'(dv_j_reg[DIV_STAGES-1].quo) * PROD_W'(dv_row_reg[DIV_STAGES-1]);
        for (int n = 0; n < 3; n++)
        begin
            pt_reg[n] <= (PT_W'(c_c[n]) <<< FRAC_BITS) + scale_term(u_c[n], mu_i_reg)
                       + scale_term(w_c[n], mu_j_reg);
            ab_neg_reg[n] <= pt_reg[n][PT_W-1];
            ab_reg[n]     <= pt_reg[n][PT_W-1] ? (PT_W-1)'(-pt_reg[n]) : (PT_W-1)'(pt_reg[n]);
            sh_ab_reg[n]  <= ab_reg[n];
            sh_neg_reg[n] <= ab_neg_reg[n];
            hv_reg[n]     <= sh_neg_reg[n] ? -COORD_W'(sh_ab_reg[n] >> sh_reg)
                                           : COORD_W'(sh_ab_reg[n] >> sh_reg);
        end
        sh_reg <= sh_next;
    end

    logic                     c1_valid;
    logic signed [CX_W-1:0]   c1_mag;
    logic signed [ANG_W-1:0]  c1_ang;
    logic [COORD_W-1:0]       c1_z;

    csg_cordic #(
        .SIDE_W (COORD_W)
    ) u_cordic_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hv_valid_reg),
        .in_x      (IN_W'(hv_reg[0])),
        .in_y      (IN_W'(hv_reg[1])),
        .in_side   (hv_reg[2]),
        .out_valid (c1_valid),
        .out_mag   (c1_mag),
        .out_ang   (c1_ang),
        .out_side  (c1_z)
    );

    logic                     hy_valid_reg;
    logic [HY_W-1:0]          hy_prod_reg;
    logic signed [ANG_W-1:0]  hy_lon_reg;
    logic [COORD_W-1:0]       hy_z_reg;
    logic [HY_W-1:0]          hy_sum;
    logic signed [IN_W-1:0]   hy_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hy_valid_reg <= 1'b0;
        end
        else
        begin
            hy_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hy_prod_reg <= HY_W'(c1_mag[R_W-1:0]) * INV_GAIN;
        hy_lon_reg  <= c1_ang;
        hy_z_reg    <= c1_z;
    end

    assign hy_sum = hy_prod_reg + HY_ROUND;
    assign hy_r   = $signed({1'b0, hy_sum[HY_W-1:HY_W-R_W]});

    logic                     c2_valid;
    logic signed [ANG_W-1:0]  c2_ang;
    logic [ANG_W-1:0]         c2_lon;

    csg_cordic #(
        .SIDE_W (ANG_W)
    ) u_cordic_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hy_valid_reg),
        .in_x      (hy_r),
        .in_y      (IN_W'($signed(hy_z_reg))),
        .in_side   (hy_lon_reg),
        .out_valid (c2_valid),
        .out_mag   (),
        .out_ang   (c2_ang),
        .out_side  (c2_lon)
    );

    logic [3:0]               dg_valid_reg;
    logic signed [LON_W-1:0]  dg_out_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dg_valid_reg <= '0;
        end
        else
        begin
            dg_valid_reg <= {dg_valid_reg[2:0], c2_valid};
        end
    end

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_deg
        localparam logic [LON_W-1:0] LIMIT = (ch == 0) ? LON_LIMIT : LAT_LIMIT;
        logic signed [ANG_W-1:0] ang;
        logic [M_W-1:0]          m_reg;
        logic                    neg1_reg;
        logic [PR_W-1:0]         pr_reg;
        logic [PC_W-1:0]         pc_reg;
        logic                    neg2_reg;
        logic [QE_W-1:0]         qe_reg;
        logic [PP_W-1:0]         pp_reg;
        logic [PC_W-1:0]         pc3_reg;
        logic                    neg3_reg;
        logic [PP_W-1:0]         lhs;
        logic [QE_W:0]           q_next;
        logic [LON_W-1:0]        q_sat;

        assign ang    = (ch == 0) ? $signed(c2_lon) : c2_ang;
        assign lhs    = PP_W'(pc3_reg) + PP_W'(PI_HALF_INT);
        assign q_next = (QE_W + 1)'(qe_reg) + (QE_W + 1)'(lhs >= pp_reg);
        assign q_sat  = (q_next > (QE_W + 1)'(LIMIT)) ? LIMIT : LON_W'(q_next);

        always_ff @(posedge clk)
        begin
            neg1_reg <= ang[ANG_W-1];
            m_reg    <= ang[ANG_W-1] ? M_W'(-ang) : M_W'(ang);
            pr_reg   <= PR_W'(m_reg) * PR_W'(DEG_RECIP);
            pc_reg   <= PC_W'(m_reg) * PC_W'(DEG_HALF_TURN);
            neg2_reg <= neg1_reg;
            qe_reg   <= pr_reg[PR_W-1:DEG_SHIFT];
            pp_reg   <= (PP_W'(pr_reg[PR_W-1:DEG_SHIFT]) + PP_W'(1)) * PP_W'(PI_DIV);
            pc3_reg  <= pc_reg;
            neg3_reg <= neg2_reg;
            dg_out_reg[ch] <= neg3_reg ? -$signed(q_sat) : $signed(q_sat);
        end
    end

    assign done      = dg_valid_reg[3];
    assign longitude = dg_out_reg[0];
    assign latitude  = dg_out_reg[1][LAT_W-1:0];

endmodule

/* rtl/csg_cordic.sv */
`timescale 1ns / 1ps
// Fully pipelined vectoring CORDIC that returns the angle and scaled magnitude of (x, y) with a side value.
// It depends on csg_pkg for widths and the arctangent table.
module csg_cordic
    import csg_pkg::*;
#(
    parameter int SIDE_W = 32
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [IN_W-1:0]   in_x,
    input  logic signed [IN_W-1:0]   in_y,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [CX_W-1:0]   out_mag,
    output logic signed [ANG_W-1:0]  out_ang,
    output logic [SIDE_W-1:0]        out_side
);

    logic [CORDIC_STEPS:0]    valid_reg;
    logic signed [CX_W-1:0]   x_reg    [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]   y_reg    [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  ang_reg  [CORDIC_STEPS+1];
    logic                     zero_reg [CORDIC_STEPS+1];
    logic [SIDE_W-1:0]        side_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
        end
    end

    // The left half-plane is turned by half a turn before the rotations.
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (in_x == '0) && (in_y == '0);
        side_reg[0] <= in_side;
        if (in_x < 0)
        begin
            x_reg[0]   <= -CX_W'(in_x);
            y_reg[0]   <= -CX_W'(in_y);
            ang_reg[0] <= (in_y >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            x_reg[0]   <= CX_W'(in_x);
            y_reg[0]   <= CX_W'(in_y);
            ang_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN_K = atan_q30(k);
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;

        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            zero_reg[k+1] <= zero_reg[k];
            side_reg[k+1] <= side_reg[k];
            if (y_reg[k] > 0)
            begin
                x_reg[k+1]   <= x_reg[k] + ys;
                y_reg[k+1]   <= y_reg[k] - xs;
                ang_reg[k+1] <= ang_reg[k] + ATAN_K;
            end
            else
            begin
                x_reg[k+1]   <= x_reg[k] - ys;
                y_reg[k+1]   <= y_reg[k] + xs;
                ang_reg[k+1] <= ang_reg[k] - ATAN_K;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_mag   = zero_reg[CORDIC_STEPS] ? '0 : x_reg[CORDIC_STEPS];
    assign out_ang   = zero_reg[CORDIC_STEPS] ? '0 : ang_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

/* rtl/csg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the cubed-sphere grid point block, attached by a bind statement.
// It depends on csg_pkg for the latency and the port widths.
module csg_checker
    import csg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic signed [LON_W-1:0]  longitude,
    input logic signed [LAT_W-1:0]  latitude
);

    // Every accepted transfer is followed by its done strobe.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted item produced no result at the expected cycle");

    // No result appears without a matching accepted transfer.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted item");

    a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (longitude <= 25'sd11796480) && (longitude >= -25'sd11796480))
        else $error("longitude out of range");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (latitude <= 24'sd5898240) && (latitude >= -24'sd5898240))
        else $error("latitude out of range");

endmodule

bind cubed_sphere_grid_point csg_checker u_csg_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cubed_sphere_grid_point: directed faces, sizes and indices,
// then random grids, all checked against a built-in fixed-point predictor of the block.
// Depends on csg_pkg and the cubed_sphere_grid_point RTL only.
module tb_top;
    import csg_pkg::*;

    typedef struct {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
    } lonlat_t;

    localparam int SIZE_CAP = 1024;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [COL_W-1:0]      col_index;
    logic [COL_W-1:0]      row_index;
    logic                  done;
    logic signed [LON_W-1:0] longitude;
    logic signed [LAT_W-1:0] latitude;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [1:0]        face_reg [3];
    logic [SIZE_W-1:0] size_i_reg;
    logic [SIZE_W-1:0] size_j_reg;
    lonlat_t           pending_points [$];
    int                mismatches;
    bit                idle_on;

    cubed_sphere_grid_point #(.MAX_POINTS(SIZE_CAP)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .col_index(col_index), .row_index(row_index),
        .done(done), .longitude(longitude), .latitude(latitude),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint arctan_pow2(input int k);
        longint unsigned acc;
        longint unsigned term;
        if (k == 0)
            return longint'(((64'hC90FDAA22168C235 >> 2) + 64'h8000_0000) >> 32);
        acc = 0;
        for (int n = 0; k * (2 * n + 1) <= 62; n++)
        begin
            term = (64'd1 << (62 - k * (2 * n + 1))) / 64'(2 * n + 1);
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return longint'((acc + 64'h8000_0000) >> 32);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x,
                                            output longint mag);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        mag = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            ang = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int k = 0; k < 31; k++)
        begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                ang = ang + arctan_pow2(k);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang = ang - arctan_pow2(k);
            end
        end
        mag = x;
        return ang;
    endfunction

    function automatic longint deg_q16(input longint ang, input longint lim);
        longint m;
        longint q;
        m = (ang < 0) ? -ang : ang;
        q = (m * 64'sd11796480 + 64'sd1686629713) / 64'sd3373259426;
        if (q > lim)
            q = lim;
        return (ang < 0) ? -q : q;
    endfunction

    function automatic longint axis_value(input logic [1:0] v);
        longint s;
        s = longint'($signed(v));
        return (s < -1) ? -1 : s;
    endfunction

    function automatic longint grid_step(input logic [SIZE_W-1:0] v);
        longint s;
        s = longint'(v);
        if (s < 2)
            s = 2;
        if (s > SIZE_CAP)
            s = SIZE_CAP;
        return ((64'sd1 << 31) + (s - 1) / 2) / (s - 1);
    endfunction

    function automatic lonlat_t grid_point(input logic [COL_W-1:0] ci,
                                           input logic [COL_W-1:0] rj);
        longint f[3];
        longint u[3];
        longint w[3];
        longint p[3];
        longint di;
        longint dj;
        longint mag;
        longint rad;
        lonlat_t res;
        for (int n = 0; n < 3; n++)
            f[n] = axis_value(face_reg[n]);
        u[0] = f[2];
        u[1] = f[0];
        u[2] = f[1];
        w[0] = f[1] * u[2] - f[2] * u[1];
        w[1] = f[2] * u[0] - f[0] * u[2];
        w[2] = f[0] * u[1] - f[1] * u[0];
        di = grid_step(size_i_reg);
        dj = grid_step(size_j_reg);
        for (int n = 0; n < 3; n++)
            p[n] = (f[n] - u[n] - w[n]) * (64'sd1 << 30)
                 + longint'(ci) * u[n] * di + longint'(rj) * w[n] * dj;
        for (int g = 0; g < 64; g++)
        begin
            if ((p[0] < (64'sd1 << 31)) && (p[0] > -(64'sd1 << 31))
                && (p[1] < (64'sd1 << 31)) && (p[1] > -(64'sd1 << 31))
                && (p[2] < (64'sd1 << 31)) && (p[2] > -(64'sd1 << 31)))
                break;
            for (int n = 0; n < 3; n++)
                p[n] = p[n] / 2;
        end
        res.lon = LON_W'(deg_q16(vector_angle(p[1], p[0], mag), 11796480));
        rad = (mag * 64'sd652032874 + (64'sd1 << 29)) >>> 30;
        res.lat = LAT_W'(deg_q16(vector_angle(p[2], rad, mag), 5898240));
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_points.push_back(grid_point(col_index, row_index));
    end

    always @(posedge clk)
    begin
        lonlat_t exp_pt;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: lon=%0d lat=%0d", longitude, latitude);
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (longitude !== exp_pt.lon || latitude !== exp_pt.lat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result differs: expected lon=%0d lat=%0d, got lon=%0d lat=%0d",
                                 exp_pt.lon, exp_pt.lat, longitude, latitude);
                end
            end
        end
    end

    task automatic pause_start(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_point(input logic [COL_W-1:0] ci, input logic [COL_W-1:0] rj);
        start     <= 1'b1;
        col_index <= ci;
        row_index <= rj;
        do
            @(posedge clk);
        while (busy);
        if (idle_on && $urandom_range(0, 3) == 0)
            pause_start($urandom_range(1, 18));
    endtask

    task automatic drain_pipeline;
        start <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FACE_X: face_reg[0] = val[1:0];
            REG_FACE_Y: face_reg[1] = val[1:0];
            REG_FACE_Z: face_reg[2] = val[1:0];
            REG_SIZE_I: size_i_reg = val;
            REG_SIZE_J: size_j_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [1:0] fx, input logic [1:0] fy, input logic [1:0] fz,
                            input logic [SIZE_W-1:0] ni, input logic [SIZE_W-1:0] nj);
        drain_pipeline();
        write_reg(REG_FACE_X, {9'(($urandom)), fx});
        write_reg(REG_FACE_Y, {9'(($urandom)), fy});
        write_reg(REG_FACE_Z, {9'(($urandom)), fz});
        write_reg(REG_SIZE_I, ni);
        write_reg(REG_SIZE_J, nj);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_grid;
        send_point(0, 0);
        send_point(1, 1);
        send_point(1, 0);
        send_point(10'h3FF, 10'h3FF);
        send_point(0, 10'h3FF);
    endtask

    task automatic test_faces;
        logic [1:0] faces [6][3];
        faces = '{'{2'b01, 2'b00, 2'b00}, '{2'b11, 2'b00, 2'b00},
                  '{2'b00, 2'b01, 2'b00}, '{2'b00, 2'b11, 2'b00},
                  '{2'b00, 2'b00, 2'b01}, '{2'b00, 2'b00, 2'b10}};
        for (int k = 0; k < 6; k++)
        begin
            set_grid(faces[k][0], faces[k][1], faces[k][2], 11'd3, 11'd1024);
            send_point(1, 512);
            send_point(2, 1023);
        end
        set_grid(2'b00, 2'b00, 2'b00, 11'd0, 11'd2047);
        send_point(10'h3FF, 0);
        set_grid(2'b01, 2'b01, 2'b01, 11'd1, 11'd1025);
        send_point(10'h3FF, 10'h3FF);
        send_point(0, 0);
        send_point(10'h155, 10'h2AA);
    endtask

    task automatic test_random_grids(input int total, input bit idle);
        logic [SIZE_W-1:0] ni;
        logic [SIZE_W-1:0] nj;
        int lim_i;
        int lim_j;
        idle_on = idle;
        for (int n = 0; n < total; n += 50)
        begin
            ni = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(2, 40));
            nj = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(2, 40));
            set_grid(2'($urandom), 2'($urandom), 2'($urandom), ni, nj);
            lim_i = (ni < 2) ? 1 : ((ni > SIZE_CAP) ? SIZE_CAP - 1 : ni - 1);
            lim_j = (nj < 2) ? 1 : ((nj > SIZE_CAP) ? SIZE_CAP - 1 : nj - 1);
            for (int m = 0; m < 50; m++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_point(COL_W'($urandom), COL_W'($urandom));
                else
                    send_point(COL_W'($urandom_range(0, lim_i)), COL_W'($urandom_range(0, lim_j)));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        col_index = '0;
        row_index = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        face_reg  = '{2'b01, 2'b00, 2'b00};
        size_i_reg = 11'd2;
        size_j_reg = 11'd2;
        mismatches = 0;
        idle_on    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_grid();
        test_faces();
        test_random_grids(600, 1'b1);
        test_random_grids(150, 1'b0);
        drain_pipeline();
        if (mismatches == 0)
            $display("cubed_sphere_grid_point: match");
        else
            $display("cubed_sphere_grid_point: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("cubed_sphere_grid_point: mismatch");
        $finish;
    end

endmodule
